/* rtl/dks_pkg.sv */
`default_nettype none

package dks_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef struct packed {
    logic signed [31:0] depth_key;
    logic        [15:0] object_handle;
    logic        [15:0] texture_handle;
    logic               last_entry;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_key;
    logic        [15:0] out_object;
    logic        [15:0] out_texture;
    logic               out_last;
    logic               overflow_seen;
  } out_item_t;

  // one stored entry: key, object, texture
  typedef struct packed {
    logic signed [31:0] key;
    logic        [15:0] object;
    logic        [15:0] texture;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch arriving item, count full check
    logic rd_prev;    // read entry below the insert position
    logic shift;      // move read entry up one place
    logic place;      // write new entry at the insert position
    logic out_start;  // rewind position for the output run
    logic rd_out;     // read entry at the output position
    logic load_out;   // fill the output register
    logic out_done;   // output item taken, advance
    logic run_clear;  // end of run, clear count and drop flag
  } dks_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic pos_zero;
    logic prev_less;
    logic new_last;
    logic last_out;
    logic out_taken;
  } dks_status_t;

endpackage

`default_nettype wire

/* rtl/depth_key_descending_sorter.sv */
// insertion: each accepted item is captured; a scan then reads stored entries from the end
//   toward entry 0, one memory read per entry, moves each with a smaller key one place along,
//   and places the new entry behind those with a key at least as large; with the store full
//   the item is dropped. One item at a time; a last item then starts the output run, which
//   reads each result through the store's single registered read port and waits on out_ready
// reset: clears the controller, entry count, drop flag and output valid; store is not cleared
`default_nettype none

module depth_key_descending_sorter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dks_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dks_pkg::out_item_t      out_data
);
  import dks_pkg::*;

  // command and status between controller and datapath
  dks_cmd_t    cmd;
  dks_status_t status;

  // controller: accepts an item only when idle, then walks the insertion
  // scan or the output run
  dks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_entry),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: sorted entry store, entry count, drop flag, output register
  dks_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

`default_nettype wire

/* rtl/dks_datapath.sv */
`default_nettype none

module dks_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dks_pkg::in_item_t  in_data,
  input  wire dks_pkg::dks_cmd_t  cmd,
  output dks_pkg::dks_status_t    status,
  output dks_pkg::out_item_t      out_data,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  import dks_pkg::*;

  entry_t           store [MAX_ENTRIES];
  entry_t           rd_data;
  entry_t           new_entry;
  logic             new_last;
  logic [CNT_W-1:0] count;
  logic             dropped;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] pos_prev;
  logic             full;

  assign full     = (count == CNT_W'(MAX_ENTRIES));
  assign pos_prev = pos - IDX_W'(1);

  // entry store, one write and one read port
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      store[pos] <= rd_data;
    end else if (cmd.place) begin
      store[pos] <= new_entry;
    end
    if (cmd.rd_prev) begin
      rd_data <= store[pos_prev];
    end else if (cmd.rd_out) begin
      rd_data <= store[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_entry.key     <= in_data.depth_key;
      new_entry.object  <= in_data.object_handle;
      new_entry.texture <= in_data.texture_handle;
      new_last          <= in_data.last_entry;
    end
    if (cmd.load_out) begin
      out_data.out_key       <= rd_data.key;
      out_data.out_object    <= rd_data.object;
      out_data.out_texture   <= rd_data.texture;
      out_data.out_last      <= status.last_out;
      out_data.overflow_seen <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          pos <= count[IDX_W-1:0];
        end
      end
      if (cmd.shift) begin
        pos <= pos_prev;
      end
      if (cmd.place) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.out_start) begin
        pos <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end
      if (cmd.out_done) begin
        out_valid <= 1'b0;
        pos       <= pos + IDX_W'(1);
      end
      if (cmd.run_clear) begin
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  always_comb begin
    status.full      = full;
    status.pos_zero  = (pos == '0);
    status.prev_less = (rd_data.key < new_entry.key);
    status.new_last  = new_last;
    status.last_out  = ((CNT_W'(pos) + CNT_W'(1)) == count);
    status.out_taken = out_valid && out_ready;
  end

endmodule

`default_nettype wire

/* rtl/dks_ctrl.sv */
`default_nettype none

module dks_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output logic                      in_ready,
  input  wire dks_pkg::dks_status_t status,
  output dks_pkg::dks_cmd_t         cmd
);
  import dks_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SHIFT_RD = 3'd1;
  localparam logic [2:0] S_SHIFT_CM = 3'd2;
  localparam logic [2:0] S_OUT_RD   = 3'd3;
  localparam logic [2:0] S_OUT_LD   = 3'd4;
  localparam logic [2:0] S_OUT_WAIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!status.full) begin
            state_next = S_SHIFT_RD;
          end else if (in_last) begin
            cmd.out_start = 1'b1;
            state_next    = S_OUT_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        if (status.pos_zero) begin
          cmd.place = 1'b1;
          if (status.new_last) begin
            cmd.out_start = 1'b1;
            state_next    = S_OUT_RD;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_SHIFT_CM;
        end
      end
      S_SHIFT_CM: begin
        if (status.prev_less) begin
          cmd.shift  = 1'b1;
          state_next = S_SHIFT_RD;
        end else begin
          cmd.place = 1'b1;
          if (status.new_last) begin
            cmd.out_start = 1'b1;
            state_next    = S_OUT_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_OUT_RD: begin
        cmd.rd_out = 1'b1;
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.load_out = 1'b1;
        state_next   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (status.out_taken) begin
          cmd.out_done = 1'b1;
          if (status.last_out) begin
            cmd.run_clear = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_OUT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import dks_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;   // long out_ready hold-off
  localparam int SETTLE_CYCLES = 40;    // quiet time after the last result

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // sorted copy of the store as the block should hold it, largest key first
  entry_t      sorted_entries [MAX_ENTRIES];
  int unsigned stored_count;
  bit          entries_lost;

  in_item_t  pending_entries [$];
  out_item_t expected_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  bit          hold_done;
  int unsigned hold_left;
  bit          in_took;

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_runs;
  int unsigned n_overflow_runs;
  int unsigned n_dropped;
  int unsigned n_errors;
  int unsigned cycle_count;

  depth_key_descending_sorter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // stable insertion of one accepted item; a last item releases the whole run
  function automatic void sort_entry(in_item_t it);
    int unsigned pos;
    if (stored_count < MAX_ENTRIES) begin
      pos = 0;
      // a new entry goes behind every entry with a key at least as large
      while (pos < stored_count && $signed(sorted_entries[pos].key) >= $signed(it.depth_key))
        pos++;
      for (int unsigned i = stored_count; i > pos; i--)
        sorted_entries[i] = sorted_entries[i - 1];
      sorted_entries[pos] = '{key: it.depth_key, object: it.object_handle,
                              texture: it.texture_handle};
      stored_count++;
    end else begin
      // store full: the item is dropped, a last item's own entry too
      entries_lost = 1'b1;
      n_dropped++;
    end
    if (it.last_entry) begin
      for (int unsigned i = 0; i < stored_count; i++)
        expected_results.push_back('{out_key: sorted_entries[i].key,
                                     out_object: sorted_entries[i].object,
                                     out_texture: sorted_entries[i].texture,
                                     out_last: (i + 1 == stored_count),
                                     overflow_seen: entries_lost});
      n_runs++;
      if (entries_lost)
        n_overflow_runs++;
      stored_count = 0;
      entries_lost = 1'b0;
    end
  endfunction

  // accepted items feed the sorter copy, results are checked against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    in_took = 1'b0;
    if (!rst) begin
      in_took = in_valid && in_ready;
      if (in_took) begin
        sort_entry(in_data);
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: out_key %0d", $signed(out_data.out_key));
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_key !== want.out_key) begin
            $error("out_key: expected %0d, actual %0d", $signed(want.out_key),
                   $signed(out_data.out_key));
            n_errors++;
          end
          if (out_data.out_object !== want.out_object) begin
            $error("out_object: expected %0d, actual %0d", want.out_object,
                   out_data.out_object);
            n_errors++;
          end
          if (out_data.out_texture !== want.out_texture) begin
            $error("out_texture: expected %0d, actual %0d", want.out_texture,
                   out_data.out_texture);
            n_errors++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last: expected %0d, actual %0d", want.out_last, out_data.out_last);
            n_errors++;
          end
          if (out_data.overflow_seen !== want.overflow_seen) begin
            $error("overflow_seen: expected %0d, actual %0d", want.overflow_seen,
                   out_data.overflow_seen);
            n_errors++;
          end
        end
      end
    end
  end

  // sender: a new item goes out only once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_entries.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_entries.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL depth_key_descending_sorter");
      $finish;
    end
  end

  function automatic void push_entry(logic [31:0] key, logic [15:0] obj, logic [15:0] tex,
                                     logic last);
    pending_entries.push_back('{depth_key: key, object_handle: obj, texture_handle: tex,
                                last_entry: last});
    n_queued++;
  endfunction

  // keys lean toward ties and extremes, the rest spread over the whole range
  function automatic logic [31:0] pick_key();
    logic [31:0] key;
    case ($urandom_range(3))
      0: key = $urandom_range(6) - 3;
      1: case ($urandom_range(3))
           0: key = 32'h8000_0000;
           1: key = 32'h7fff_ffff;
           2: key = 32'h0000_0000;
           default: key = 32'hffff_ffff;
         endcase
      default: key = $urandom();
    endcase
    return key;
  endfunction

  // one full set of n entries, the final one marked last
  function automatic void queue_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      push_entry(pick_key(), 16'($urandom_range(65535)),
                 ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535)), i + 1 == n);
  endfunction

  // block until every queued item is taken and every expected result has come
  task automatic drain();
    while (n_accepted != n_queued || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    send_idle_pct = 24;
    recv_idle_pct = 61;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lone entry at the top key with all-ones handles
    push_entry(32'h7fff_ffff, 16'hffff, 16'hffff, 1'b1);
    // extremes of the key, ties at 5 and at the minimum, zero handles
    push_entry(32'h8000_0000, 16'h0000, 16'h0000, 1'b0);
    push_entry(32'd5,         16'd1,    16'd2,    1'b0);
    push_entry(32'd5,         16'd2,    16'd0,    1'b0);
    push_entry(32'hffff_ffff, 16'h00ff, 16'hff00, 1'b0);
    push_entry(32'h7fff_ffff, 16'h5555, 16'haaaa, 1'b0);
    push_entry(32'd5,         16'd3,    16'd4,    1'b0);
    push_entry(32'h8000_0000, 16'd7,    16'd8,    1'b0);
    push_entry(32'd0,         16'haaaa, 16'h5555, 1'b1);
    // all keys equal, arrival order must survive
    push_entry(-32'sd7, 16'd10, 16'd11, 1'b0);
    push_entry(-32'sd7, 16'd12, 16'd13, 1'b0);
    push_entry(-32'sd7, 16'd14, 16'd15, 1'b1);
    // rising keys, each lands at the top of the store; the last item's key 0 goes to the bottom
    push_entry(32'd1, 16'd21, 16'd1, 1'b0);
    push_entry(32'd2, 16'd22, 16'd2, 1'b0);
    push_entry(32'd3, 16'd23, 16'd3, 1'b0);
    push_entry(32'd4, 16'd24, 16'd4, 1'b0);
    push_entry(32'd0, 16'd25, 16'd5, 1'b1);
    // sender pause until every result is back
    drain();

    // sender idles lightly, receiver heavily
    for (int i = 0; i < 5; i++)
      queue_set($urandom_range(6, 1));
    drain();

    // roles swapped; one set overruns the store so the tail, last item included, is dropped
    send_idle_pct = 61;
    recv_idle_pct = 24;
    queue_set(MAX_ENTRIES + 3);
    queue_set($urandom_range(6, 1));
    queue_set($urandom_range(6, 1));
    drain();

    // no idling; the receiver holds off long while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 3; i++)
      queue_set($urandom_range(6, 1));
    hold_req = 1'b1;
    for (int i = 0; i < 3; i++)
      queue_set($urandom_range(8, 2));
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items in %0d sorted runs, %0d result items checked", n_accepted,
             n_runs, n_results);
    $display("%0d runs overflowed the store, %0d entries dropped", n_overflow_runs, n_dropped);
    if (n_errors == 0)
      $display("PASS depth_key_descending_sorter");
    else
      $display("FAIL depth_key_descending_sorter");
    $finish;
  end

endmodule

/* sim.f */
rtl/dks_pkg.sv
rtl/dks_datapath.sv
rtl/dks_ctrl.sv
rtl/depth_key_descending_sorter.sv
tb/tb_top.sv
